// ===== rtl/cer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cer_pkg
// Shared types and constants of the coalescing event ring
// ----------------------------------------------------------------------------
package cer_pkg;

	localparam int RING_SLOTS_DEF = 16;

	localparam int KIND_W  = 32;
	localparam int VALUE_W = 32;
	localparam int TIME_W  = 64;
	localparam int DROP_W  = 64;
	localparam int OCC_W   = 4;
	localparam int STAT_W  = 3;

	typedef enum logic [STAT_W-1:0] {
		ST_STORED    = 3'd0,
		ST_COALESCED = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_POPPED    = 3'd3,
		ST_EMPTY     = 3'd4
	} cer_status_t;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef struct packed {
		logic store;
		logic coalesce;
		logic pop;
	} cer_act_t;

endpackage

// ===== rtl/coalescing_event_ring_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_event_ring_core
// Event ring with coalescing of pushes into a full ring and a drop counter
// ----------------------------------------------------------------------------
// Accepts one push or pop transaction per clock unless the input stalls. The
// input register captures the transaction when it is accepted; the result
// register is loaded from it once the result side advances, and drives the
// outputs. The ring holds RING_SLOTS-1 events; the three stores are memories
// with one write port and one registered read port that prefetches the oldest
// entry, so a pop finds it already read. The kind of the newest entry is kept
// in a register for the coalescing compare. The result side can stall; the
// input stalls only while the input register is occupied and the result
// register holds a result that is being stalled.
module coalescing_event_ring_core #(
	parameter int RING_SLOTS = cer_pkg::RING_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [cer_pkg::KIND_W-1:0]   event_kind,
	input  logic [cer_pkg::VALUE_W-1:0]  event_value,
	input  logic [cer_pkg::TIME_W-1:0]   time_now,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cer_pkg::STAT_W-1:0]   status,
	output logic [cer_pkg::KIND_W-1:0]   out_kind,
	output logic [cer_pkg::VALUE_W-1:0]  out_value,
	output logic [cer_pkg::TIME_W-1:0]   out_time,
	output logic [cer_pkg::OCC_W-1:0]    occupancy,
	output logic [cer_pkg::DROP_W-1:0]   drop_total
);

	localparam int PTR_W = $clog2(RING_SLOTS);

	logic                        vld_s1;
	logic                        req_type_s1;
	logic [cer_pkg::KIND_W-1:0]  event_kind_s1;
	logic [cer_pkg::VALUE_W-1:0] event_value_s1;
	logic [cer_pkg::TIME_W-1:0]  time_now_s1;

	logic                        out_valid_q;
	cer_pkg::cer_status_t        status_q;
	logic [cer_pkg::KIND_W-1:0]  out_kind_q;
	logic [cer_pkg::VALUE_W-1:0] out_value_q;
	logic [cer_pkg::TIME_W-1:0]  out_time_q;
	logic [cer_pkg::OCC_W-1:0]   occupancy_q;
	logic [cer_pkg::DROP_W-1:0]  drop_total_q;

	logic                        adv;
	logic                        fire;
	cer_pkg::cer_act_t           act;
	logic [PTR_W-1:0]            wr_addr;
	logic [PTR_W-1:0]            rd_addr_d;
	cer_pkg::cer_status_t        status_d;
	logic [cer_pkg::OCC_W-1:0]   occupancy_d;
	logic [cer_pkg::DROP_W-1:0]  drop_d;
	logic [cer_pkg::KIND_W-1:0]  head_kind;
	logic [cer_pkg::VALUE_W-1:0] head_value;
	logic [cer_pkg::TIME_W-1:0]  head_time;

	assign adv      = !out_valid_q || !out_stall;
	assign fire     = vld_s1 && adv;
	assign in_stall = vld_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1    <= req_type;
			event_kind_s1  <= event_kind;
			event_value_s1 <= event_value;
			time_now_s1    <= time_now;
		end
	end

	cer_ctrl #(
		.RING_SLOTS(RING_SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req_type   (req_type_s1),
		.event_kind (event_kind_s1),
		.act        (act),
		.wr_addr    (wr_addr),
		.rd_addr_d  (rd_addr_d),
		.status_d   (status_d),
		.occupancy_d(occupancy_d),
		.drop_d     (drop_d)
	);

	cer_slot_mem #(
		.DEPTH(RING_SLOTS),
		.WIDTH(cer_pkg::KIND_W)
	) u_kind_mem (
		.clk  (clk),
		.we   (fire && act.store),
		.waddr(wr_addr),
		.wdata(event_kind_s1),
		.raddr(rd_addr_d),
		.rdata(head_kind)
	);

	cer_slot_mem #(
		.DEPTH(RING_SLOTS),
		.WIDTH(cer_pkg::VALUE_W)
	) u_value_mem (
		.clk  (clk),
		.we   (fire && (act.store || act.coalesce)),
		.waddr(wr_addr),
		.wdata(event_value_s1),
		.raddr(rd_addr_d),
		.rdata(head_value)
	);

	cer_slot_mem #(
		.DEPTH(RING_SLOTS),
		.WIDTH(cer_pkg::TIME_W)
	) u_time_mem (
		.clk  (clk),
		.we   (fire && (act.store || act.coalesce)),
		.waddr(wr_addr),
		.wdata(time_now_s1),
		.raddr(rd_addr_d),
		.rdata(head_time)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			drop_total_q <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= vld_s1;
			end
			if (fire) begin
				drop_total_q <= drop_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status_d;
			out_kind_q  <= act.pop ? head_kind : '0;
			out_value_q <= act.pop ? head_value : '0;
			out_time_q  <= act.pop ? head_time : '0;
			occupancy_q <= occupancy_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_kind   = out_kind_q;
	assign out_value  = out_value_q;
	assign out_time   = out_time_q;
	assign occupancy  = occupancy_q;
	assign drop_total = drop_total_q;

	a_drop_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (status_d == cer_pkg::ST_COALESCED || status_d == cer_pkg::ST_DROPPED)
		|=> drop_total_q == $past(drop_total_q) + 1'b1)
		else $error("drop count did not advance on a full push");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == cer_pkg::ST_EMPTY |-> occupancy_q == '0)
		else $error("empty status with nonzero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == cer_pkg::ST_DROPPED || status_q == cer_pkg::ST_COALESCED)
		|-> occupancy_q == cer_pkg::OCC_W'(RING_SLOTS - 1))
		else $error("full status without a full ring");

endmodule

// ===== rtl/cer_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cer_slot_mem
// One ring store: single write port, registered read port with write bypass
// ----------------------------------------------------------------------------
module cer_slot_mem #(
	parameter int DEPTH = cer_pkg::RING_SLOTS_DEF,
	parameter int WIDTH = cer_pkg::KIND_W,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/cer_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cer_ctrl
// Ring pointers, drop counter and per-transaction decision
// ----------------------------------------------------------------------------
module cer_ctrl #(
	parameter int RING_SLOTS = cer_pkg::RING_SLOTS_DEF,
	localparam int PTR_W = $clog2(RING_SLOTS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        req_type,
	input  logic [cer_pkg::KIND_W-1:0]  event_kind,
	output cer_pkg::cer_act_t           act,
	output logic [PTR_W-1:0]            wr_addr,
	output logic [PTR_W-1:0]            rd_addr_d,
	output cer_pkg::cer_status_t        status_d,
	output logic [cer_pkg::OCC_W-1:0]   occupancy_d,
	output logic [cer_pkg::DROP_W-1:0]  drop_d
);

	localparam int OCC_EXT_W = (PTR_W + 1 > cer_pkg::OCC_W) ? PTR_W + 1 : cer_pkg::OCC_W;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_SLOTS - 1);

	logic [PTR_W-1:0]           wp_q;
	logic [PTR_W-1:0]           rp_q;
	logic [cer_pkg::DROP_W-1:0] drop_q;
	logic [cer_pkg::KIND_W-1:0] newest_kind_q;

	logic [PTR_W-1:0] wp_next;
	logic [PTR_W-1:0] wp_prev;
	logic [PTR_W-1:0] rp_next;
	logic [PTR_W-1:0] wp_d;
	logic             full;
	logic             empty;
	logic             full_push;
	logic [PTR_W:0]   diff;
	logic [PTR_W:0]   cnt;
	logic [OCC_EXT_W-1:0] occ_ext;

	assign wp_next = (wp_q == LAST) ? '0 : wp_q + 1'b1;
	assign wp_prev = (wp_q == '0) ? LAST : wp_q - 1'b1;
	assign rp_next = (rp_q == LAST) ? '0 : rp_q + 1'b1;
	assign full    = (wp_next == rp_q);
	assign empty   = (wp_q == rp_q);

	always_comb begin
		act          = '0;
		full_push    = 1'b0;
		status_d     = cer_pkg::ST_EMPTY;
		priority if (req_type == cer_pkg::REQ_PUSH) begin
			if (!full) begin
				act.store = 1'b1;
				status_d  = cer_pkg::ST_STORED;
			end else begin
				full_push = 1'b1;
				if (!empty && (newest_kind_q == event_kind)) begin
					act.coalesce = 1'b1;
					status_d     = cer_pkg::ST_COALESCED;
				end else begin
					status_d = cer_pkg::ST_DROPPED;
				end
			end
		end else if (!empty) begin
			act.pop  = 1'b1;
			status_d = cer_pkg::ST_POPPED;
		end else begin
			status_d = cer_pkg::ST_EMPTY;
		end
	end

	assign wr_addr   = act.store ? wp_q : wp_prev;
	assign wp_d      = (fire && act.store) ? wp_next : wp_q;
	assign rd_addr_d = (fire && act.pop) ? rp_next : rp_q;
	assign drop_d    = drop_q + cer_pkg::DROP_W'(full_push);

	assign diff        = {1'b0, wp_d} - {1'b0, rd_addr_d};
	assign cnt         = diff[PTR_W] ? diff + (PTR_W + 1)'(RING_SLOTS) : diff;
	assign occ_ext     = OCC_EXT_W'(cnt);
	assign occupancy_d = occ_ext[cer_pkg::OCC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			drop_q <= '0;
		end else if (fire) begin
			wp_q   <= wp_d;
			rp_q   <= rd_addr_d;
			drop_q <= drop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && act.store) begin
			newest_kind_q <= event_kind;
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the coalescing event ring core
// ----------------------------------------------------------------------------
// Push and pop transactions go in through a valid/stall channel. Each accepted
// transaction is run through an in-bench model of the ring, which covers
// storing, coalescing into the newest entry on a full ring, dropping and
// popping. The model's result, or the table's for checked directed rows, is
// queued. Results coming out of the block are checked in order against that
// queue. A directed table comes first: empty pop, fill to capacity, coalesce,
// drop and pointer wrap. Random traffic follows with a shifting push/pop mix,
// random idling on both sides, one long receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb;
	import cer_pkg::*;

	localparam int SLOTS        = RING_SLOTS_DEF;
	localparam int RANDOM_ITEMS = 925;
	localparam int QUIET_ITEMS  = 100;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_ITEMS   = 24;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_AT     = 600;
	localparam int MIX_SPAN     = 40;
	localparam int STALL_LIMIT  = 2000;
	localparam int MAX_REPORTS  = 10;
	localparam int PUSH_BIAS [5] = '{90, 70, 50, 30, 10};

	typedef struct packed {
		logic               op;
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [TIME_W-1:0]  stamp;
	} ring_req_t;

	typedef struct packed {
		cer_status_t        stat;
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [TIME_W-1:0]  stamp;
		logic [OCC_W-1:0]   occ;
		logic [DROP_W-1:0]  drops;
	} ring_resp_t;

	typedef struct packed {
		ring_req_t  rq;
		logic       typed;
		ring_resp_t want;
	} seq_row_t;

	localparam ring_resp_t NO_CHECK = '0;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic               req_type    = REQ_PUSH;
	logic [KIND_W-1:0]  event_kind  = '0;
	logic [VALUE_W-1:0] event_value = '0;
	logic [TIME_W-1:0]  time_now    = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [KIND_W-1:0]  out_kind;
	logic [VALUE_W-1:0] out_value;
	logic [TIME_W-1:0]  out_time;
	logic [OCC_W-1:0]   occupancy;
	logic [DROP_W-1:0]  drop_total;

	// model state of the ring
	logic [KIND_W-1:0]  ring_kind  [SLOTS];
	logic [VALUE_W-1:0] ring_value [SLOTS];
	logic [TIME_W-1:0]  ring_stamp [SLOTS];
	int                 wr_idx = 0;
	int                 rd_idx = 0;
	logic [DROP_W-1:0]  drop_tally = '0;

	ring_resp_t pending_results [$];
	int         accepted_in  = 0;
	int         results_out  = 0;
	int         mismatches   = 0;
	int         seen_status [5] = '{default: 0};
	bit         quiet         = 1'b0;
	bit         long_hold_req = 1'b0;

	seq_row_t directed_rows [25] = '{
		'{'{REQ_POP,  32'h0000_0000, 32'h0000_0000, 64'h0}, 1'b1,
			'{ST_EMPTY, 32'h0, 32'h0, 64'h0, 4'd0, 64'd0}},
		'{'{REQ_PUSH, 32'h0000_0000, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'hFFFF_FFFF, 32'h0000_0000, 64'h0000_0000_0000_0000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h8000_0000, 32'h0000_0001, 64'h8000_0000_0000_0000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0001, 32'h8000_0000, 64'h0000_0000_0000_0001}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h5555_5555, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'hAAAA_AAAA, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0002, 32'h1234_5678, 64'h0000_0000_0000_1000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0003, 32'h9ABC_DEF0, 64'h0000_0000_0000_2000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0002, 32'h0F0F_0F0F, 64'h0000_0000_0000_3000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0004, 32'hF0F0_F0F0, 64'h0000_0000_0000_4000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0005, 32'h0000_FFFF, 64'h0000_0000_0000_5000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0006, 32'hFFFF_0000, 64'h0000_0000_0000_6000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0006, 32'h0000_0042, 64'h0000_0000_0000_7000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0007, 32'hDEAD_BEEF, 64'h0000_0001_0000_0000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0007, 32'hCAFE_F00D, 64'h0000_0002_0000_0000}, 1'b1,
			'{ST_COALESCED, 32'h0, 32'h0, 64'h0, 4'd15, 64'd1}},
		'{'{REQ_PUSH, 32'hFFFF_FFFF, 32'h1111_1111, 64'h0000_0003_0000_0000}, 1'b1,
			'{ST_DROPPED, 32'h0, 32'h0, 64'h0, 4'd15, 64'd2}},
		'{'{REQ_PUSH, 32'h0000_0007, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, NO_CHECK},
		'{'{REQ_POP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
			'{ST_POPPED, 32'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd14, 64'd3}},
		'{'{REQ_PUSH, 32'h0000_0009, 32'h2222_2222, 64'h0000_0004_0000_0000}, 1'b0, NO_CHECK},
		'{'{REQ_POP,  32'h0000_0000, 32'h0000_0000, 64'h0000_0000_0000_0000}, 1'b0, NO_CHECK},
		'{'{REQ_POP,  32'h0000_0000, 32'h0000_0000, 64'h0000_0000_0000_0000}, 1'b0, NO_CHECK},
		'{'{REQ_PUSH, 32'h0000_0009, 32'h3333_3333, 64'h0000_0005_0000_0000}, 1'b0, NO_CHECK},
		'{'{REQ_POP,  32'h0000_0000, 32'h0000_0000, 64'h0000_0000_0000_0000}, 1'b0, NO_CHECK}
	};

	coalescing_event_ring_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.event_kind (event_kind),
		.event_value(event_value),
		.time_now   (time_now),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_kind   (out_kind),
		.out_value  (out_value),
		.out_time   (out_time),
		.occupancy  (occupancy),
		.drop_total (drop_total)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic bit ring_full();
		return ((wr_idx + 1) % SLOTS) == rd_idx;
	endfunction

	function automatic ring_resp_t ring_apply(ring_req_t rq);
		ring_resp_t rs;
		int         newest;
		rs = '0;
		if (rq.op == REQ_PUSH) begin
			if (ring_full()) begin
				newest = (wr_idx + SLOTS - 1) % SLOTS;
				if (ring_kind[newest] == rq.kind) begin
					ring_value[newest] = rq.value;
					ring_stamp[newest] = rq.stamp;
					rs.stat = ST_COALESCED;
				end else begin
					rs.stat = ST_DROPPED;
				end
				drop_tally = drop_tally + 1'b1;
			end else begin
				ring_kind[wr_idx]  = rq.kind;
				ring_value[wr_idx] = rq.value;
				ring_stamp[wr_idx] = rq.stamp;
				wr_idx = (wr_idx + 1) % SLOTS;
				rs.stat = ST_STORED;
			end
		end else if (wr_idx != rd_idx) begin
			rs.kind  = ring_kind[rd_idx];
			rs.value = ring_value[rd_idx];
			rs.stamp = ring_stamp[rd_idx];
			rd_idx = (rd_idx + 1) % SLOTS;
			rs.stat = ST_POPPED;
		end else begin
			rs.stat = ST_EMPTY;
		end
		rs.occ   = OCC_W'((wr_idx + SLOTS - rd_idx) % SLOTS);
		rs.drops = drop_tally;
		return rs;
	endfunction

	task automatic drive_request(input ring_req_t rq, input bit allow_gap, input bit typed,
			input ring_resp_t given);
		ring_resp_t predicted;
		in_valid    <= 1'b1;
		req_type    <= rq.op;
		event_kind  <= rq.kind;
		event_value <= rq.value;
		time_now    <= rq.stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		accepted_in++;
		predicted = ring_apply(rq);
		pending_results.push_back(typed ? given : predicted);
		if (allow_gap && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	// receiver: short random stall bursts, plus one long hold-off on request
	initial begin : rx_side
		int hold_left;
		int burst_left;
		hold_left  = 0;
		burst_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
			end else if (long_hold_req) begin
				hold_left     = HOLD_CYCLES;
				long_hold_req = 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 3);
			end
			out_stall <= (hold_left > 0) || (burst_left > 0);
		end
	end

	always @(posedge clk) begin : result_check
		ring_resp_t got;
		ring_resp_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{cer_status_t'(status), out_kind, out_value, out_time, occupancy, drop_total};
			results_out++;
			if (got.stat <= ST_EMPTY)
				seen_status[got.stat]++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result transaction: st=%0d kind=%h value=%h time=%h",
						got.stat, got.kind, got.value, got.stamp);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"result %0d: expected st=%0d kind=%h value=%h time=%h ",
							"occ=%0d drops=%0d, got st=%0d kind=%h value=%h time=%h ",
							"occ=%0d drops=%0d"},
							results_out, want.stat, want.kind, want.value, want.stamp,
							want.occ, want.drops, got.stat, got.kind, got.value,
							got.stamp, got.occ, got.drops);
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no transaction for %0d cycles, %0d results outstanding",
			STALL_LIMIT, pending_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		ring_req_t rq;
		int        push_pct;
		push_pct = 50;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			drive_request(directed_rows[r].rq, 1'b1, directed_rows[r].typed,
				directed_rows[r].want);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % MIX_SPAN == 0)
				push_pct = PUSH_BIAS[$urandom_range(0, 4)];
			if (i == HOLD_AT)
				long_hold_req = 1'b1;
			if (i == DRAIN_AT) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			rq.op    = ($urandom_range(1, 100) <= push_pct) ? REQ_PUSH : REQ_POP;
			rq.value = $urandom;
			rq.stamp = {$urandom, $urandom};
			if (rq.op == REQ_PUSH && ring_full() && $urandom_range(0, 1) == 1)
				rq.kind = ring_kind[(wr_idx + SLOTS - 1) % SLOTS];
			else if ($urandom_range(0, 3) == 0)
				rq.kind = $urandom;
			else
				rq.kind = KIND_W'($urandom_range(0, 3));
			drive_request(rq, !quiet && (i < HOLD_AT || i >= HOLD_AT + HOLD_ITEMS),
				1'b0, NO_CHECK);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6)
			@(posedge clk);

		$display("covered %0d transactions in and %0d out, final drop count %0d",
			accepted_in, results_out, drop_tally);
		$display("results: %0d stored, %0d coalesced, %0d dropped, %0d popped, %0d empty",
			seen_status[ST_STORED], seen_status[ST_COALESCED], seen_status[ST_DROPPED],
			seen_status[ST_POPPED], seen_status[ST_EMPTY]);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
